@@ rtl/fmpa_pkg.sv @@
// Package for the FM modulator: widths, state codes and the sine table.
`default_nettype none

package fmpa_pkg;

   localparam int PHASE_BITS  = 32;
   localparam int TABLE_BITS  = 10;
   localparam int SAMPLE_BITS = 16;
   localparam int OUT_BITS    = 16;
   localparam int SENS_BITS   = 32;

   localparam int TAB_SIZE  = 1 << TABLE_BITS;
   localparam int FRAC_BITS = PHASE_BITS - TABLE_BITS;
   // Table entries are Q2.30; the neighbor difference stays below 2*pi/TAB_SIZE.
   localparam int TAB_W     = 32;
   localparam int DIFF_W    = 34 - TABLE_BITS;
   localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;
   localparam int INCP_W    = SENS_BITS + SAMPLE_BITS;
   localparam int RND_SHIFT = 31 - OUT_BITS;
   localparam int RND_W     = TAB_W + 2 - RND_SHIFT;

   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1) << (PHASE_BITS - 2);

   localparam longint CORDIC_X0 = 652032874;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_RD_COS,
      S_MUL_COS,
      S_MUL_SIN,
      S_FIN
   } state_type;

   typedef logic signed [TAB_W-1:0] sine_tab_type [TAB_SIZE];

   localparam longint ATAN_TURN [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000
   };

   // Rotation-mode CORDIC on a 2^32-per-turn angle, giving the sine in Q2.30.
   // Only evaluated while the table constant is built.
   function automatic longint cordic_sin(input longint angle);
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     neg;
      z   = angle;
      x   = CORDIC_X0;
      y   = 0;
      neg = 1'b0;
      if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
      // Fold into a half turn about zero; a folded result is negated.
      if (z >= 64'sd1073741824) begin
         z   = z - 64'sd2147483648;
         neg = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z   = z + 64'sd2147483648;
         neg = 1'b1;
      end
      for (int i = 0; i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TURN[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TURN[i];
         end
         x = nx;
      end
      return neg ? -y : y;
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      longint       ang;
      for (int k = 0; k < TAB_SIZE; k++) begin
         ang    = longint'(k) << (32 - TABLE_BITS);
         tab[k] = TAB_W'(cordic_sin(ang));
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

@@ rtl/fmpa_if.sv @@
// Valid/ready channel interfaces for the modulator's sample and I/Q words.
`default_nettype none

interface fmpa_req_if import fmpa_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface fmpa_rsp_if import fmpa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] i_out;
   logic signed [OUT_BITS-1:0] q_out;

   modport source (output valid, output i_out, output q_out, input ready);
   modport sink   (input valid, input i_out, input q_out, output ready);
endinterface

`default_nettype wire

@@ rtl/fm_modulator_phase_accum_sincos.sv @@
// FM modulator: phase accumulator driving an interpolated sine/cosine table.
//
//   channel   direction  word
//   req_ch    in         sample, signed Q1.15
//   rsp_ch    out        i_out (cosine), q_out (sine), signed Q1.15
//   csr_      in         sensitivity, 32-bit signed, write only
//
// A word passes through the accumulate, cosine read, cosine multiply, sine
// multiply and finish states to the result register; the input is ready
// again only in idle, so no new word is taken before the last one is through.
// The sine table has a registered read port and one interpolation multiplier,
// which are used once for the cosine and once for the sine of every word.
// Reset clears the phase, the sensitivity and the result valid flag.
// A new sample is taken while a finished result waits; the sequencer holds
// in its last step only if the previous result has still not been taken.
`default_nettype none

module fm_modulator_phase_accum_sincos import fmpa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   fmpa_req_if.sink                  req_ch,
   fmpa_rsp_if.source                rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [SENS_BITS-1:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic signed [SENS_BITS-1:0]  sens_ff;
   logic        [PHASE_BITS-1:0] phase_ff, phase_in;
   logic signed [INCP_W-1:0]     incp_ff, incp_in;

   logic        [PHASE_BITS-1:0] rd_phase;
   logic        [TABLE_BITS-1:0] rd_idx;
   logic        [TABLE_BITS-1:0] rd_idx_next;
   logic signed [TAB_W-1:0]      t0_ff, t1_ff;
   logic        [FRAC_BITS-1:0]  frac_ff;

   logic signed [TAB_W:0]        diff_full;
   logic signed [DIFF_W-1:0]     diff;
   logic signed [FRAC_BITS:0]    frac_s;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [TAB_W-1:0]      base_ff;
   logic signed [OUT_BITS-1:0]   interp;
   logic signed [OUT_BITS-1:0]   i_ff;

   logic                         rsp_valid_ff;
   logic signed [OUT_BITS-1:0]   rsp_i_ff, rsp_q_ff;

   logic                         accept;
   logic                         acc_en;
   logic                         mul_en;
   logic                         i_en;
   logic                         rsp_load;
   logic                         rsp_free;

   // Table value plus the interpolation step, rounded half up and saturated.
   function automatic logic signed [OUT_BITS-1:0] interp_out(
      input logic signed [TAB_W-1:0]  base,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [DIFF_W-1:0] step;
      logic signed [TAB_W:0]    v;
      logic signed [TAB_W+1:0]  sum;
      logic signed [RND_W-1:0]  r;
      logic signed [OUT_BITS-1:0] omax;
      logic signed [OUT_BITS-1:0] omin;
      omax = {1'b0, {(OUT_BITS-1){1'b1}}};
      omin = {1'b1, {(OUT_BITS-1){1'b0}}};
      step = prod[FRAC_BITS +: DIFF_W];
      v    = (TAB_W+1)'(base) + (TAB_W+1)'(step);
      sum  = (TAB_W+2)'(v) + (TAB_W+2)'(1 << (RND_SHIFT - 1));
      r    = sum[TAB_W+1:RND_SHIFT];
      if (r > RND_W'(omax)) begin
         return omax;
      end else if (r < RND_W'(omin)) begin
         return omin;
      end
      return r[OUT_BITS-1:0];
   endfunction

   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      acc_en       = 1'b0;
      mul_en       = 1'b0;
      i_en         = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) state_in = S_ACC;
         end
         S_ACC: begin
            acc_en   = 1'b1;
            state_in = S_RD_COS;
         end
         S_RD_COS: begin
            state_in = S_MUL_COS;
         end
         S_MUL_COS: begin
            mul_en   = 1'b1;
            state_in = S_MUL_SIN;
         end
         S_MUL_SIN: begin
            mul_en   = 1'b1;
            i_en     = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff <= '0;
      end else if (csr_wr_en) begin
         sens_ff <= csr_wr_data;
      end
   end

   // Phase increment: sample times sensitivity, floor-shifted by the sample's
   // fraction bits, kept modulo one turn.
   assign incp_in  = sens_ff * req_ch.sample;
   assign phase_in = phase_ff + incp_ff[SAMPLE_BITS-1 +: PHASE_BITS];

   always_ff @(posedge clock) begin
      if (accept) begin
         incp_ff <= incp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (acc_en) begin
         phase_ff <= phase_in;
      end
   end

   // The cosine read uses the phase a quarter turn ahead; the sine read
   // follows in the cycle after.
   assign rd_phase    = (state_ff == S_RD_COS) ? (phase_ff + QUARTER_TURN) : phase_ff;
   assign rd_idx      = rd_phase[PHASE_BITS-1 -: TABLE_BITS];
   assign rd_idx_next = rd_idx + TABLE_BITS'(1);

   always_ff @(posedge clock) begin
      t0_ff   <= SINE_TAB[rd_idx];
      t1_ff   <= SINE_TAB[rd_idx_next];
      frac_ff <= rd_phase[FRAC_BITS-1:0];
   end

   assign diff_full = (TAB_W+1)'(t1_ff) - (TAB_W+1)'(t0_ff);
   assign diff      = diff_full[DIFF_W-1:0];
   assign frac_s    = {1'b0, frac_ff};
   assign prod_in   = diff * frac_s;
   assign interp    = interp_out(base_ff, prod_ff);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
         base_ff <= t0_ff;
      end
      if (i_en) begin
         i_ff <= interp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_i_ff <= i_ff;
         rsp_q_ff <= interp;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.i_out = rsp_i_ff;
   assign rsp_ch.q_out = rsp_q_ff;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the FM modulator: sample stream in, I/Q words out.
`timescale 1ns / 100ps

module tb_top import fmpa_pkg::*; ();

   typedef struct {
      logic [OUT_BITS-1:0] i_val;
      logic [OUT_BITS-1:0] q_val;
   } iq_word_type;

   localparam int          QUIET_LIMIT = 2000;
   localparam int          LUT_SIZE    = 1024;
   localparam logic [31:0] QUARTER     = 32'h4000_0000;
   localparam longint      HALF        = 64'sd2147483648;
   localparam longint      QTR         = 64'sd1073741824;
   localparam longint      TURN        = 64'sd4294967296;

   // Arctangent of 2^-n in 2^32-per-turn units.
   localparam longint ATAN_STEP [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [SENS_BITS-1:0] csr_wr_data;

   fmpa_req_if req_ch ();
   fmpa_rsp_if rsp_ch ();

   fm_modulator_phase_accum_sincos u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   longint                        sin_lut [LUT_SIZE];
   logic signed [SAMPLE_BITS-1:0] pending_samples [$];
   iq_word_type                   iq_expected [$];
   logic signed [31:0]            sens_model;
   logic [31:0]                   phase_model;
   int                            mismatch_cnt = 0;
   int                            quiet_cycles = 0;
   int                            req_gap      = 0;
   int                            rsp_hold     = 0;
   bit                            req_calm     = 1'b0;
   bit                            rsp_calm     = 1'b0;

   always #4 clock = ~clock;

   // Sine in Q2.30 by rotation-mode CORDIC; the angle is first folded into
   // the half turn about zero.
   function automatic longint sine_q30(input longint ang);
      longint z;
      longint x;
      longint y;
      longint x_nxt;
      bit     flip;
      z    = ang;
      x    = 652032874;
      y    = 0;
      flip = 1'b0;
      if (z >= HALF) z = z - TURN;
      if (z >= QTR) begin
         z    = z - HALF;
         flip = 1'b1;
      end else if (z < -QTR) begin
         z    = z + HALF;
         flip = 1'b1;
      end
      for (int n = 0; n < 32; n++) begin
         if (z >= 0) begin
            x_nxt = x - (y >>> n);
            y     = y + (x >>> n);
            z     = z - ATAN_STEP[n];
         end else begin
            x_nxt = x + (y >>> n);
            y     = y - (x >>> n);
            z     = z + ATAN_STEP[n];
         end
         x = x_nxt;
      end
      return flip ? -y : y;
   endfunction

   // Interpolated table sine of a phase, rounded and saturated to Q1.15.
   function automatic logic [OUT_BITS-1:0] iq_lookup(input logic [31:0] ph);
      int     idx;
      longint t0;
      longint t1;
      longint fr;
      longint v;
      longint r;
      idx = ph[31:22];
      fr  = ph[21:0];
      t0  = sin_lut[idx];
      t1  = sin_lut[(idx + 1) % LUT_SIZE];
      v   = t0 + (((t1 - t0) * fr) >>> 22);
      r   = (v + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[OUT_BITS-1:0];
   endfunction

   function automatic int idle_len(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         1, 2:    return 16'($urandom_range(0, 255)) - 16'sd128;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_samples.size() != 0 || iq_expected.size() != 0 || req_ch.valid)
         @(posedge clock);
   endtask

   // The block must be idle before the sensitivity changes.
   task automatic write_sens(input logic [31:0] v);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Sample driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_gap > 0 || pending_samples.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.sample <= pending_samples.pop_front();
            req_ch.valid  <= 1'b1;
            if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
            req_gap = idle_len(req_calm);
         end
      end
   end

   // Phase accumulator and I/Q prediction for every accepted sample.
   always @(posedge clock) begin
      longint      prod;
      iq_word_type w;
      if (reset) begin
         sens_model  = '0;
         phase_model = '0;
      end else begin
         if (csr_wr_en) sens_model = csr_wr_data;
         if (req_ch.valid && req_ch.ready) begin
            prod        = longint'(sens_model) * longint'(req_ch.sample);
            phase_model = phase_model + 32'(prod >>> 15);
            w.i_val     = iq_lookup(phase_model + QUARTER);
            w.q_val     = iq_lookup(phase_model);
            iq_expected.push_back(w);
         end
      end
   end

   // Result sink with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            rsp_hold = idle_len(rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Checker: each I/Q word against the oldest prediction.
   always @(posedge clock) begin
      iq_word_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (iq_expected.size() == 0) begin
            $error("I/Q word with no sample pending: i_out %0d q_out %0d",
                   rsp_ch.i_out, rsp_ch.q_out);
            mismatch_cnt++;
         end else begin
            w = iq_expected.pop_front();
            if (rsp_ch.i_out !== w.i_val) begin
               $error("i_out: expected %0d, got %0d", $signed(w.i_val), rsp_ch.i_out);
               mismatch_cnt++;
            end
            if (rsp_ch.q_out !== w.q_val) begin
               $error("q_out: expected %0d, got %0d", $signed(w.q_val), rsp_ch.q_out);
               mismatch_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] sens;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      for (int k = 0; k < LUT_SIZE; k++) sin_lut[k] = sine_q30(longint'(k) << 22);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Zero sensitivity keeps the phase at zero: cosine saturates at full scale.
      pending_samples.push_back(16'sh7FFF);
      pending_samples.push_back(16'sh8000);

      // Exact quarter-turn steps walk the axes and wrap the accumulator.
      write_sens(32'h4000_0000);
      repeat (5) pending_samples.push_back(16'sh8000);

      write_sens(32'h7FFF_FFFF);
      pending_samples.push_back(16'sh7FFF);
      pending_samples.push_back(16'sh8000);
      pending_samples.push_back(16'sh0000);
      pending_samples.push_back(16'sh0001);
      pending_samples.push_back(16'shFFFF);
      pending_samples.push_back(16'sh5555);
      pending_samples.push_back(16'shAAAA);

      write_sens(32'h8000_0000);
      pending_samples.push_back(16'sh7FFF);
      pending_samples.push_back(16'sh8000);
      pending_samples.push_back(16'shFFFF);
      pending_samples.push_back(16'sh0001);
      pending_samples.push_back(16'sh7F00);

      // Tiny sensitivity: the shift floors toward minus infinity.
      write_sens(32'd1);
      pending_samples.push_back(16'sh8000);
      pending_samples.push_back(16'sh7FFF);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       sens = 32'h7FFF_FFFF;
            1:       sens = 32'h8000_0000;
            3:       sens = $urandom_range(0, 32'h0400_0000);
            4:       sens = -$urandom_range(1, 32'h0400_0000);
            5:       sens = 32'hFFFF_FFFF;
            7:       sens = 32'h0000_0000;
            default: sens = $urandom();
         endcase
         write_sens(sens);
         repeat (140) pending_samples.push_back(rand_sample());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
